[rtl/assert_macros.svh]
// Assertion macros for the checker file of the frame allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, off while rst is high.
`define CFA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst is high.
`define CFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cfa_pkg.sv]
// Types and constants shared by the contiguous frame allocator files.
`default_nettype none

package cfa_pkg;

  localparam int unsigned FRAME_W = 20;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned TDATA_W = 40;
  localparam int unsigned PAD_W   = TDATA_W - FRAME_W - CNT_W;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned MARK_W  = 2;

  // frame_count after reset
  localparam int unsigned FRAME_COUNT_RST = 8192;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_NO_ROOM  = 3'd1,
    STAT_RANGE    = 3'd2,
    STAT_ZERO     = 3'd3,
    STAT_NOT_HEAD = 3'd4
  } status_t;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_BASE    = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_RESERVE = 2'd2;

  // frame mark encoding: bit 0 used, bit 1 head
  localparam int unsigned MARK_USED_BIT = 0;
  localparam int unsigned MARK_HEAD_BIT = 1;
  localparam logic [MARK_W-1:0] MARK_FREE      = 2'b00;
  localparam logic [MARK_W-1:0] MARK_USED      = 2'b01;
  localparam logic [MARK_W-1:0] MARK_HEAD_USED = 2'b11;

endpackage

`default_nettype wire

[rtl/contiguous_frame_allocator.sv]
// Contiguous frame allocator top level: first-fit search over a frame mark RAM.
//
// Use: command beats enter on the s_ stream (s_tuser = operation; s_tdata = frame,
// count). Every command gives exactly one result beat on the m_ stream
// (m_tuser = status; m_tdata = first_frame, free_frames). Registers base_frame,
// frame_count and reserve_first sit on the APB port at byte offsets 0, 4, 8;
// write them only while no command is in flight.
// One command is worked at a time; s_tready is high only in the idle state.
// Each command works through the single RAM walk from accept to result beat:
//   allocate  scans frames (up to the pool size), then marks count frames
//   release   frees the head and the frames behind it, up to the pool end at most
//   mark      walks count frames
//   initialize clears all MAX_FRAMES marks (clearing pass writes one mark per cycle)
//   rejected commands (zero count, out of range) go straight to the result
// Reset runs the same clearing pass over MAX_FRAMES marks with s_tready low;
// register writes are taken during it. No result beat follows reset.
// The result sits in an output register, so a new command is accepted while a
// result still waits; if the receiver stalls longer, the next result holds in
// the sequencer and s_tready stays low until the output register frees up.
`default_nettype none

module contiguous_frame_allocator #(
  parameter int unsigned MAX_FRAMES = 8192
) (
  input  logic                           clk,
  input  logic                           rst,
  // commands
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cfa_pkg::TDATA_W-1:0]    s_tdata,   // frame[19:0], count[33:20], zero pad
  input  logic [cfa_pkg::OP_W-1:0]       s_tuser,   // operation[1:0]
  // results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cfa_pkg::TDATA_W-1:0]    m_tdata,   // first_frame[19:0], free_frames[33:20], zero pad
  output logic [cfa_pkg::STAT_W-1:0]     m_tuser,   // status[2:0]
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfa_pkg::PADDR_W-1:0]    paddr,
  input  logic [cfa_pkg::APB_W-1:0]      pwdata,
  output logic [cfa_pkg::APB_W-1:0]      prdata,
  output logic                           pready
);

  import cfa_pkg::*;

  localparam int unsigned IW       = $clog2(MAX_FRAMES);
  localparam int unsigned XW       = ((IW > CNT_W) ? IW : CNT_W) + 1;
  localparam int unsigned CAP      = (MAX_FRAMES > ((1 << CNT_W) - 1)) ?
                                     ((1 << CNT_W) - 1) : MAX_FRAMES;
  localparam int unsigned RST_POOL = (MAX_FRAMES < FRAME_COUNT_RST) ?
                                     MAX_FRAMES : FRAME_COUNT_RST;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC_SCAN,
    S_ALLOC_MARK,
    S_REL_HEAD,
    S_REL_WALK,
    S_MARK_WALK,
    S_REPLY
  } state_t;

  // configuration registers
  logic [FRAME_W-1:0] base_frame;
  logic [CNT_W-1:0]   frame_count;
  logic               reserve_first;

  // sequencer state
  state_t             state;
  op_t                op;
  logic [FRAME_W-1:0] off;        // command frame less base_frame
  logic               below;      // command frame lies below base_frame
  logic [CNT_W-1:0]   cnt;
  logic [IW-1:0]      idx;        // frame whose marks arrive from the RAM this cycle
  logic [IW-1:0]      start;
  logic [CNT_W-1:0]   run;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   free_count;
  logic               clr_res;
  logic               clr_reply;
  logic [FRAME_W-1:0] res_first;
  status_t            res_status;

  // RAM port
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [MARK_W-1:0]  ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [MARK_W-1:0]  ram_rdata;

  logic [CNT_W-1:0]   pool_n;
  logic [FRAME_W:0]   off_full;
  logic               idx_last;
  logic               q_used;
  logic               q_head;
  logic [CNT_W-1:0]   run_inc;
  logic               off_out;
  logic               mark_over;
  logic               cfg_we;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame    <= '0;
      frame_count   <= CNT_W'(FRAME_COUNT_RST);
      reserve_first <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_BASE:    base_frame    <= pwdata[FRAME_W-1:0];
        REG_COUNT:   frame_count   <= pwdata[CNT_W-1:0];
        REG_RESERVE: reserve_first <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE:    prdata = APB_W'(base_frame);
      REG_COUNT:   prdata = APB_W'(frame_count);
      REG_RESERVE: prdata = APB_W'(reserve_first);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  // pool size in use: frame_count clamped to the store depth
  assign pool_n    = (frame_count > CNT_W'(CAP)) ? CNT_W'(CAP) : frame_count;
  assign off_full  = {1'b0, s_tdata[FRAME_W-1:0]} - {1'b0, base_frame};
  assign idx_last  = (XW'(idx) + XW'(1)) == XW'(pool_n);
  assign q_used    = ram_rdata[MARK_USED_BIT];
  assign q_head    = ram_rdata[MARK_HEAD_BIT];
  assign run_inc   = run + CNT_W'(1);
  assign off_out   = below || (off >= FRAME_W'(pool_n));
  assign mark_over = ((FRAME_W+1)'(off) + (FRAME_W+1)'(cnt)) > (FRAME_W+1)'(pool_n);

  assign s_tready  = (state == S_IDLE);

  // RAM control: read one frame ahead of the one being evaluated
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = MARK_FREE;
    ram_raddr = idx + IW'(1);
    unique case (state)
      S_DECODE: begin
        ram_raddr = (op == OP_ALLOC) ? '0 : off[IW-1:0];
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = ((idx == '0) && clr_res) ? MARK_USED : MARK_FREE;
      end
      S_ALLOC_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = (idx == start) ? MARK_HEAD_USED : MARK_USED;
      end
      S_REL_HEAD: begin
        ram_we = q_head;
      end
      S_REL_WALK: begin
        ram_we = q_used && !q_head;
      end
      S_MARK_WALK: begin
        ram_we    = !q_used;
        ram_wdata = MARK_USED;
      end
      default: ;
    endcase
  end

  cfa_ram #(
    .WIDTH (MARK_W),
    .DEPTH (MAX_FRAMES)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      clr_res    <= 1'b0;
      clr_reply  <= 1'b0;
      free_count <= CNT_W'(RST_POOL);
      m_tvalid   <= 1'b0;
    end else begin
      // drop the taken beat unless the reply state reloads it in this cycle
      if (m_tvalid && m_tready && (state != S_REPLY)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        // sweep the whole store, one mark per cycle
        S_CLEAR: begin
          if (idx == IW'(MAX_FRAMES - 1)) begin
            state <= clr_reply ? S_REPLY : S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        S_IDLE: begin
          if (s_tvalid) begin
            op         <= op_t'(s_tuser);
            cnt        <= s_tdata[FRAME_W +: CNT_W];
            off        <= off_full[FRAME_W-1:0];
            below      <= off_full[FRAME_W];
            res_first  <= '0;
            res_status <= STAT_OK;
            state      <= S_DECODE;
          end
        end

        // range checks, then start the walk
        S_DECODE: begin
          unique case (op)
            OP_ALLOC: begin
              if (cnt == '0) begin
                res_status <= STAT_ZERO;
                state      <= S_REPLY;
              end else if (cnt > pool_n) begin
                res_status <= STAT_RANGE;
                state      <= S_REPLY;
              end else begin
                idx   <= '0;
                run   <= '0;
                state <= S_ALLOC_SCAN;
              end
            end
            OP_RELEASE: begin
              if (off_out) begin
                res_status <= STAT_RANGE;
                state      <= S_REPLY;
              end else begin
                idx   <= off[IW-1:0];
                state <= S_REL_HEAD;
              end
            end
            OP_MARK: begin
              if (cnt == '0) begin
                res_status <= STAT_ZERO;
                state      <= S_REPLY;
              end else if (off_out || mark_over) begin
                res_status <= STAT_RANGE;
                state      <= S_REPLY;
              end else begin
                idx   <= off[IW-1:0];
                rem   <= cnt;
                state <= S_MARK_WALK;
              end
            end
            OP_INIT: begin
              clr_res    <= reserve_first && (pool_n != '0);
              free_count <= pool_n - CNT_W'(reserve_first && (pool_n != '0));
              clr_reply  <= 1'b1;
              idx        <= '0;
              state      <= S_CLEAR;
            end
          endcase
        end

        // count free frames; stop at the first run long enough
        S_ALLOC_SCAN: begin
          if (!q_used && (run_inc == cnt)) begin
            start      <= idx - IW'(cnt - CNT_W'(1));
            free_count <= free_count - cnt;
            state      <= S_ALLOC_MARK;
          end else if (idx_last) begin
            res_status <= STAT_NO_ROOM;
            state      <= S_REPLY;
          end else begin
            run <= q_used ? '0 : run_inc;
            idx <= idx + IW'(1);
          end
        end

        // write the run back to front; the head goes last
        S_ALLOC_MARK: begin
          if (idx == start) begin
            res_first <= base_frame + FRAME_W'(start);
            state     <= S_REPLY;
          end else begin
            idx <= idx - IW'(1);
          end
        end

        S_REL_HEAD: begin
          if (!q_head) begin
            res_status <= STAT_NOT_HEAD;
            state      <= S_REPLY;
          end else begin
            free_count <= free_count + CNT_W'(1);
            if (idx_last) begin
              state <= S_REPLY;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_REL_WALK;
            end
          end
        end

        // free the tail until a free frame, another head or the pool end
        S_REL_WALK: begin
          if (!q_used || q_head) begin
            state <= S_REPLY;
          end else begin
            free_count <= free_count + CNT_W'(1);
            if (idx_last) begin
              state <= S_REPLY;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end

        S_MARK_WALK: begin
          if (!q_used) begin
            free_count <= free_count - CNT_W'(1);
          end
          if (rem == CNT_W'(1)) begin
            state <= S_REPLY;
          end else begin
            rem <= rem - CNT_W'(1);
            idx <= idx + IW'(1);
          end
        end

        // hold the result until the output register is free
        S_REPLY: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {{PAD_W{1'b0}}, free_count, res_first};
            m_tuser   <= res_status;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/cfa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
`default_nettype none

module cfa_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/cfa_check.sv]
// Port-level checker for the contiguous frame allocator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module cfa_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [cfa_pkg::TDATA_W-1:0] m_tdata,
  input wire logic [cfa_pkg::STAT_W-1:0]  m_tuser
);

  import cfa_pkg::*;

  // stalled result beat holds
  `CFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // one command at a time: ready drops after every accepted beat
  `CFA_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready, "command accepted while busy")

  // store is being cleared right after reset
  `CFA_ASSERT(a_clear_after_reset, $fell(rst), !s_tready, "ready during post-reset clear")

  // only a successful allocate carries a frame number
  `CFA_ASSERT(a_fail_no_frame, m_tvalid && (m_tuser != STAT_OK), m_tdata[FRAME_W-1:0] == '0, "frame on failed result")

  // padding above free_frames stays zero
  `CFA_ASSERT(a_pad_zero, m_tvalid, m_tdata[TDATA_W-1:FRAME_W+CNT_W] == '0, "nonzero result padding")

endmodule

bind contiguous_frame_allocator cfa_check u_cfa_check (.*);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for the contiguous frame allocator: directed table, then random phases.

module tb_top;
  import cfa_pkg::*;

  localparam int MAX_FRAMES = 8192;
  localparam logic [FRAME_W-1:0] TOP_FRAME = '1;

  // one command beat as the block sees it
  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   count;
  } command_t;

  // one result beat, field by field
  typedef struct packed {
    logic [FRAME_W-1:0] first;
    status_t            status;
    logic [CNT_W-1:0]   free;
  } outcome_t;

  // directed table row: either a register write or a command, the latter with an
  // optional hand-typed outcome
  typedef struct packed {
    logic             is_reg;
    logic [1:0]       reg_idx;
    logic [APB_W-1:0] value;
    command_t         cmd;
    logic             typed;
    outcome_t         want;
  } plan_row_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;   // frame[19:0], count[33:20], zero pad
  logic [OP_W-1:0]    s_tuser  = '0;   // operation[1:0]
  logic               m_tvalid;
  logic               m_tready = 1'b1;
  logic [TDATA_W-1:0] m_tdata;         // first_frame[19:0], free_frames[33:20], zero pad
  logic [STAT_W-1:0]  m_tuser;         // status[2:0]
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [APB_W-1:0]   pwdata   = '0;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  contiguous_frame_allocator #(.MAX_FRAMES(MAX_FRAMES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: registers, per-frame marks and the free counter.
  logic [MARK_W-1:0]  frame_mark [MAX_FRAMES];
  logic [FRAME_W-1:0] base_reg;
  logic [CNT_W-1:0]   count_reg;
  logic               reserve_reg;
  logic [CNT_W-1:0]   free_left;

  outcome_t pending_outcomes [$];   // expected result beats, oldest first
  int       mismatch_count = 0;
  bit       steady = 1'b0;          // set: neither side idles in this phase

  // Pool size in use: frame_count clamped to the RAM depth.
  function automatic int pool_frames();
    if (int'(count_reg) > MAX_FRAMES) return MAX_FRAMES;
    return int'(count_reg);
  endfunction

  // Rebuild the marks as initialize does: all free, frame 0 held back on request.
  function automatic void clear_marks();
    int n;
    n = pool_frames();
    foreach (frame_mark[i]) frame_mark[i] = MARK_FREE;
    free_left = n[CNT_W-1:0];
    if (reserve_reg && n > 0) begin
      frame_mark[0] = MARK_USED;
      free_left = free_left - CNT_W'(1);
    end
  endfunction

  // Apply one command to the shadow and return the result beat it must produce.
  function automatic outcome_t allocator_outcome(command_t c);
    outcome_t r;
    int n, run, off, start, i, k;
    bit found;
    n = pool_frames();
    r.first = '0;
    r.status = STAT_OK;
    case (c.op)
      OP_ALLOC: begin
        if (c.count == 0) begin
          r.status = STAT_ZERO;
        end else if (int'(c.count) > n) begin
          r.status = STAT_RANGE;
        end else begin
          // first fit: take the first window of count free frames
          r.status = STAT_NO_ROOM;
          run = 0;
          found = 1'b0;
          for (i = 0; i < n && !found; i++) begin
            if (frame_mark[i][MARK_USED_BIT]) begin
              run = 0;
            end else begin
              run++;
              if (run == int'(c.count)) begin
                found = 1'b1;
                start = i + 1 - run;
                for (k = start; k <= i; k++) frame_mark[k] = MARK_USED;
                frame_mark[start] = MARK_HEAD_USED;
                free_left = free_left - c.count;
                r.first = base_reg + start[FRAME_W-1:0];
                r.status = STAT_OK;
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        if (c.frame < base_reg) begin
          r.status = STAT_RANGE;
        end else begin
          off = int'(c.frame - base_reg);
          if (off >= n) begin
            r.status = STAT_RANGE;
          end else if (!frame_mark[off][MARK_HEAD_BIT]) begin
            r.status = STAT_NOT_HEAD;
          end else begin
            // free the head, then walk on through used frames that head nothing
            frame_mark[off] = MARK_FREE;
            free_left = free_left + CNT_W'(1);
            i = off + 1;
            while (i < n && frame_mark[i][MARK_USED_BIT] && !frame_mark[i][MARK_HEAD_BIT]) begin
              frame_mark[i] = MARK_FREE;
              free_left = free_left + CNT_W'(1);
              i++;
            end
          end
        end
      end
      OP_MARK: begin
        if (c.count == 0) begin
          r.status = STAT_ZERO;
        end else if (c.frame < base_reg) begin
          r.status = STAT_RANGE;
        end else begin
          off = int'(c.frame - base_reg);
          if (off >= n || int'(c.count) > n - off) begin
            r.status = STAT_RANGE;
          end else begin
            // only free frames change; used ones keep their head mark
            for (i = off; i < off + int'(c.count); i++) begin
              if (!frame_mark[i][MARK_USED_BIT]) begin
                frame_mark[i] = MARK_USED;
                free_left = free_left - CNT_W'(1);
              end
            end
          end
        end
      end
      default: begin
        clear_marks();
      end
    endcase
    r.free = free_left;
    return r;
  endfunction

  // Offset of a random live head in the pool, -1 when there is none.
  function automatic int some_head();
    int heads [$];
    int n, i;
    n = pool_frames();
    for (i = 0; i < n; i++) begin
      if (frame_mark[i][MARK_HEAD_BIT]) heads.push_back(i);
    end
    if (heads.size() == 0) return -1;
    return heads[$urandom_range(0, heads.size() - 1)];
  endfunction

  // Mostly well-formed traffic: allocations that fit, releases of live heads,
  // marks inside the pool; the rest is noise over the full field widths.
  function automatic command_t random_command();
    command_t c;
    int n, pick, head, off;
    logic [31:0] rnd;
    n = pool_frames();
    rnd = $urandom;
    c.frame = rnd[FRAME_W-1:0];
    rnd = $urandom;
    c.count = rnd[CNT_W-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      c.op = OP_ALLOC;
      if ($urandom_range(0, 9) != 0) begin
        off = $urandom_range(1, (n > 3) ? n / 3 : 1);
        c.count = off[CNT_W-1:0];
      end
    end else if (pick < 68) begin
      c.op = OP_RELEASE;
      head = some_head();
      off = (head >= 0 && $urandom_range(0, 4) != 0) ? head : $urandom_range(0, n + 1);
      c.frame = base_reg + off[FRAME_W-1:0];
    end else if (pick < 82) begin
      c.op = OP_MARK;
      off = (n > 0) ? $urandom_range(0, n - 1) : 0;
      c.frame = base_reg + off[FRAME_W-1:0];
      off = $urandom_range(0, 4);
      c.count = off[CNT_W-1:0];
    end else if (pick < 86) begin
      c.op = OP_INIT;
    end else begin
      c.op = op_t'($urandom_range(0, 3));
    end
    return c;
  endfunction

  function automatic int idle_cycles();
    if (steady) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Send one command beat; predict its result at the accepting edge.
  // Valid is only dropped here when a gap is drawn, so back-to-back beats keep
  // it high across the edge.
  task automatic issue(input command_t c, input logic typed, input outcome_t want);
    int gap;
    outcome_t predicted;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, c.count, c.frame};
    s_tuser  <= c.op;
    @(posedge clk);
    while ((s_tvalid && s_tready) !== 1'b1) @(posedge clk);
    predicted = allocator_outcome(c);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  // APB write; with more set, psel stays high for a back-to-back setup.
  task automatic write_reg(input logic [1:0] idx, input logic [APB_W-1:0] value,
                           input logic more);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    penable <= 1'b0;
    if (!more) psel <= 1'b0;
    case (idx)
      REG_BASE:    base_reg    = value[FRAME_W-1:0];
      REG_COUNT:   count_reg   = value[CNT_W-1:0];
      REG_RESERVE: reserve_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic plan_row_t cmd_row(op_t op, int frame, int count);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = '0;
    r.value = '0;
    r.cmd.op = op;
    r.cmd.frame = frame[FRAME_W-1:0];
    r.cmd.count = count[CNT_W-1:0];
    r.typed = 1'b0;
    r.want.first = '0;
    r.want.status = STAT_OK;
    r.want.free = '0;
    return r;
  endfunction

  function automatic plan_row_t checked_row(op_t op, int frame, int count, int first,
                                            status_t st, int free_n);
    plan_row_t r;
    r = cmd_row(op, frame, count);
    r.typed = 1'b1;
    r.want.first = first[FRAME_W-1:0];
    r.want.status = st;
    r.want.free = free_n[CNT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, int value);
    plan_row_t r;
    r = cmd_row(OP_INIT, 0, 0);
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  // Result side: draw a stall per beat, then check the beat against the oldest
  // expectation.
  initial begin : result_side
    outcome_t want;
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end
      @(posedge clk);
      while ((m_tvalid && m_tready) !== 1'b1) @(posedge clk);
      if (pending_outcomes.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending, status %0d", m_tuser));
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tdata[FRAME_W-1:0] !== want.first)
          flag_mismatch($sformatf("first_frame %0d, expected %0d",
                                  m_tdata[FRAME_W-1:0], want.first));
        if (m_tuser !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
        if (m_tdata[FRAME_W+CNT_W-1:FRAME_W] !== want.free)
          flag_mismatch($sformatf("free_frames %0d, expected %0d",
                                  m_tdata[FRAME_W+CNT_W-1:FRAME_W], want.free));
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    command_t c;
    outcome_t none;
    int phase;
    logic [31:0] rnd;
    logic [FRAME_W-1:0] base_pick;
    logic [CNT_W-1:0] size_pick;

    // shadow starts from the reset register values
    base_reg = '0;
    count_reg = CNT_W'(FRAME_COUNT_RST);
    reserve_reg = 1'b0;
    clear_marks();
    none.first = '0;
    none.status = STAT_OK;
    none.free = '0;

    // Full pool after reset: rejects first, then fill, overflow and empty it.
    plan.push_back(checked_row(OP_ALLOC, 0, 0, 0, STAT_ZERO, 8192));
    plan.push_back(checked_row(OP_ALLOC, 0, 16383, 0, STAT_RANGE, 8192));
    plan.push_back(checked_row(OP_MARK, 0, 0, 0, STAT_ZERO, 8192));
    plan.push_back(checked_row(OP_ALLOC, 0, 8192, 0, STAT_OK, 0));
    plan.push_back(checked_row(OP_ALLOC, 0, 1, 0, STAT_NO_ROOM, 0));
    plan.push_back(checked_row(OP_RELEASE, 0, 0, 0, STAT_OK, 8192));
    plan.push_back(checked_row(OP_RELEASE, 0, 0, 0, STAT_NOT_HEAD, 8192));
    plan.push_back(checked_row(OP_RELEASE, 1048575, 16383, 0, STAT_RANGE, 8192));
    // block frame 0, so the next run has to end on the last frame of the pool
    plan.push_back(checked_row(OP_MARK, 0, 1, 0, STAT_OK, 8191));
    plan.push_back(checked_row(OP_ALLOC, 0, 8191, 1, STAT_OK, 0));
    plan.push_back(checked_row(OP_RELEASE, 1, 0, 0, STAT_OK, 8191));
    plan.push_back(cmd_row(OP_ALLOC, 0, 3));
    // mark over a mix of used and free frames, then one past the end
    plan.push_back(checked_row(OP_MARK, 0, 8192, 0, STAT_OK, 0));
    plan.push_back(checked_row(OP_MARK, 8191, 2, 0, STAT_RANGE, 0));
    // release walks on through the marked frames behind the head
    plan.push_back(cmd_row(OP_RELEASE, 1, 0));
    plan.push_back(checked_row(OP_INIT, 0, 0, 0, STAT_OK, 8192));
    // small pool near the top of the frame space, first frame reserved
    plan.push_back(reg_row(REG_BASE, 1048570));
    plan.push_back(reg_row(REG_COUNT, 16));
    plan.push_back(reg_row(REG_RESERVE, 1));
    plan.push_back(checked_row(OP_INIT, 0, 0, 0, STAT_OK, 15));
    plan.push_back(checked_row(OP_ALLOC, 0, 10, 1048571, STAT_OK, 5));
    plan.push_back(cmd_row(OP_ALLOC, 0, 5));            // head frame wraps past 2^20
    plan.push_back(cmd_row(OP_RELEASE, 1048569, 0));    // below the pool
    plan.push_back(cmd_row(OP_RELEASE, 1048570, 0));    // reserved frame, no head
    plan.push_back(cmd_row(OP_RELEASE, 1048571, 0));
    // empty pool: everything is out of range, nothing is reserved
    plan.push_back(reg_row(REG_COUNT, 0));
    plan.push_back(cmd_row(OP_ALLOC, 0, 1));
    plan.push_back(cmd_row(OP_MARK, 1048570, 1));
    plan.push_back(cmd_row(OP_INIT, 0, 0));
    // oversize frame_count clamps to the RAM depth
    plan.push_back(reg_row(REG_COUNT, 16383));
    plan.push_back(reg_row(REG_BASE, 1048575));
    plan.push_back(checked_row(OP_INIT, 0, 0, 0, STAT_OK, 8191));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; drain before the first of a group of register writes.
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) begin
          s_tvalid <= 1'b0;
          wait_idle();
        end
        write_reg(plan[i].reg_idx, plan[i].value, (i + 1 < plan.size()) && plan[i+1].is_reg);
      end else begin
        issue(plan[i].cmd, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new settings each time, usually followed by initialize.
    // Pools stay small so searches and walks are short; phase 0 is a one-frame pool.
    for (phase = 0; phase < 6; phase++) begin
      s_tvalid <= 1'b0;
      wait_idle();
      rnd = $urandom;
      case ($urandom_range(0, 2))
        0:       base_pick = '0;
        1:       base_pick = TOP_FRAME - rnd[5:0];
        default: base_pick = rnd[FRAME_W-1:0];
      endcase
      rnd = $urandom_range(4, 48);
      size_pick = (phase == 0) ? 14'd1 : rnd[CNT_W-1:0];
      rnd = $urandom;
      write_reg(REG_BASE, APB_W'(base_pick), 1'b1);
      write_reg(REG_COUNT, APB_W'(size_pick), 1'b1);
      write_reg(REG_RESERVE, APB_W'(rnd[0]), 1'b0);
      steady = (phase % 3 == 1);
      // skipping initialize now and then leaves stale marks under the new pool
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        c = random_command();
        c.op = OP_INIT;
        issue(c, 1'b0, none);
      end
      repeat (12) issue(random_command(), 1'b0, none);
    end

    // Drop valid, drain, then give a stray beat time to show up.
    s_tvalid <= 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Hang guard: well beyond the slowest legal run, including the reset clear.
  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/cfa_pkg.sv
rtl/cfa_ram.sv
rtl/contiguous_frame_allocator.sv
rtl/cfa_check.sv
tb/tb_top.sv
